// ===== hdl/isbn_pkg.sv =====
// Shared types, character codes and small modulo helpers for the ISBN check-digit validator.
package isbn_pkg;

  // Character codes
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_UC_X   = 8'h58;
  localparam logic [7:0] CHAR_LC_X   = 8'h78;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Lengths and limits
  localparam logic [3:0] COUNT_LIMIT  = 4'd14;
  localparam logic [3:0] TEN_LEN      = 4'd10;
  localparam logic [3:0] THIRTEEN_LEN = 4'd13;

  // X as the ISBN-10 check character: weight 10 times value 10
  localparam logic [6:0] X_TERM = 7'd100;

  // Modulo constants; reciprocals are scaled by 2^11 and round down
  localparam logic [6:0]  MOD11       = 7'd11;
  localparam logic [14:0] MOD11_RECIP = 15'd186;
  localparam logic [5:0]  MOD10       = 6'd10;
  localparam logic [13:0] MOD10_RECIP = 14'd204;
  localparam logic [5:0]  WEIGHT_3    = 6'd3;

  typedef enum logic [1:0] {
    FMT_BAD      = 2'd0,
    FMT_TEN      = 2'd1,
    FMT_THIRTEEN = 2'd2
  } fmt_t;

  typedef struct packed {
    logic is_valid;
    fmt_t format_kind;
  } verdict_t;

  // p mod 11 for p <= 110; the quotient estimate is at most one low
  function automatic logic [3:0] mod11(input logic [6:0] p);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(p) * MOD11_RECIP;
    q    = prod[14:11];
    r    = p - 7'(q) * MOD11;
    if (r >= MOD11) begin
      r = r - MOD11;
    end
    return r[3:0];
  endfunction

  // p mod 10 for p <= 36
  function automatic logic [3:0] mod10(input logic [5:0] p);
    logic [13:0] prod;
    logic [2:0]  q;
    logic [5:0]  r;
    prod = 14'(p) * MOD10_RECIP;
    q    = prod[13:11];
    r    = p - 6'(q) * MOD10;
    if (r >= MOD10) begin
      r = r - MOD10;
    end
    return r[3:0];
  endfunction

endpackage

// ===== hdl/isbn_acc.sv =====
// Running ISBN-10/ISBN-13 check state and the end-of-string verdict.
module isbn_acc
  import isbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output verdict_t   verdict
);

  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] ten_sum_r, ten_sum_nxt;
  logic [3:0] thr_sum_r, thr_sum_nxt;
  logic       ten_bad_r, ten_bad_nxt;
  logic       thr_bad_r, thr_bad_nxt;

  logic       is_sep;
  logic       is_digit;
  logic       is_x;
  logic [7:0] char_off;
  logic [3:0] digit;
  logic [3:0] ten_weight;
  logic [6:0] ten_term;
  logic [5:0] thr_term;

  always_comb begin
    is_sep     = (char_code == CHAR_HYPHEN) || (char_code == CHAR_SPACE);
    is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    is_x       = (char_code == CHAR_UC_X) || (char_code == CHAR_LC_X);
    char_off   = char_code - CHAR_ZERO;
    digit      = is_digit ? char_off[3:0] : 4'd0;
    ten_weight = cnt_r + 4'd1;
    ten_term   = 7'(ten_weight) * 7'(digit);
    thr_term   = cnt_r[0] ? 6'(digit) * WEIGHT_3 : 6'(digit);

    cnt_nxt     = cnt_r;
    ten_sum_nxt = ten_sum_r;
    thr_sum_nxt = thr_sum_r;
    ten_bad_nxt = ten_bad_r;
    thr_bad_nxt = thr_bad_r;

    if (!is_sep) begin
      if (cnt_r < TEN_LEN) begin
        if (is_digit) begin
          ten_sum_nxt = mod11(7'(ten_sum_r) + ten_term);
        end else if ((cnt_r == TEN_LEN - 4'd1) && is_x) begin
          ten_sum_nxt = mod11(7'(ten_sum_r) + X_TERM);
        end else begin
          ten_bad_nxt = 1'b1;
        end
      end
      if (cnt_r < THIRTEEN_LEN) begin
        if (is_digit) begin
          thr_sum_nxt = mod10(6'(thr_sum_r) + thr_term);
        end else begin
          thr_bad_nxt = 1'b1;
        end
      end
      if (cnt_r < COUNT_LIMIT) begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end

    verdict.is_valid    = 1'b0;
    verdict.format_kind = FMT_BAD;
    if (cnt_nxt == TEN_LEN) begin
      verdict.format_kind = FMT_TEN;
      verdict.is_valid    = !ten_bad_nxt && (ten_sum_nxt == 4'd0);
    end else if (cnt_nxt == THIRTEEN_LEN) begin
      verdict.format_kind = FMT_THIRTEEN;
      verdict.is_valid    = !thr_bad_nxt && (thr_sum_nxt == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last_char)) begin
      cnt_r     <= '0;
      ten_sum_r <= '0;
      thr_sum_r <= '0;
      ten_bad_r <= 1'b0;
      thr_bad_r <= 1'b0;
    end else if (step_en) begin
      cnt_r     <= cnt_nxt;
      ten_sum_r <= ten_sum_nxt;
      thr_sum_r <= thr_sum_nxt;
      ten_bad_r <= ten_bad_nxt;
      thr_bad_r <= thr_bad_nxt;
    end
  end

endmodule

// ===== hdl/isbn_check_digit_validator.sv =====
// Top level of the ISBN check-digit validator: input register, check state, result register.
//
// Usage:
//   The in_ channel carries one ASCII character per transaction in in_tdata, with
//   in_tlast set on the final character of a string. Hyphens and spaces are
//   skipped. Every string yields exactly one out_ transaction, produced by the
//   character with in_tlast; other characters produce none.
//   out_tdata[0] is the verdict (1 = valid ISBN-10 or ISBN-13) and out_tuser
//   gives the format: 0 wrong length, 1 ten characters, 2 thirteen characters.
// Flow:
//   One character per cycle while in_tready is high. The input register takes
//   the final character first; its check update is then loaded into the result
//   register, which raises out_tvalid.
// Reset:
//   rst_n is synchronous, active low; it empties both registers and clears the
//   running sums, count and bad-character flags.
// Stall:
//   While a result waits in the output register, non-final characters keep
//   flowing. in_tready drops only when a final character sits in the input
//   register and the result register is still occupied and not being taken.
module isbn_check_digit_validator
  import isbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] is_valid, [7:1] zero
  output logic [1:0] out_tuser   // [1:0] format_kind
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       advance;
  logic       load_out;
  logic       out_valid_r;
  verdict_t   verdict;
  verdict_t   out_verdict_r;

  // A non-final character never needs the result register
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign load_out  = advance && s1_last_r;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  isbn_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .char_code (s1_char_r),
    .last_char (s1_last_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_verdict_r.is_valid};
  assign out_tuser  = out_verdict_r.format_kind;

  // Backpressure only comes from a final character blocked by a full result register
  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("in_tready low without a blocked final character");

  // Result register is never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // A taken result with nothing new behind it leaves the register empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !load_out) |=> !out_valid_r)
    else $error("result not cleared after transaction");

  // Wrong length is never reported valid
  a_bad_len_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_verdict_r.format_kind == FMT_BAD) && out_verdict_r.is_valid))
    else $error("valid verdict with wrong length");

endmodule
